// File: src/vrps_pkg.sv
// shared types and constants for the video register port and scroll timing core
package vrps_pkg;

	localparam logic [1:0] FUNC_TICK  = 2'd0;
	localparam logic [1:0] FUNC_READ  = 2'd1;
	localparam logic [1:0] FUNC_WRITE = 2'd2;
	localparam logic [1:0] FUNC_NONE  = 2'd3;

	localparam logic [2:0] REG_CTRL    = 3'd0;
	localparam logic [2:0] REG_MASK    = 3'd1;
	localparam logic [2:0] REG_STATUS  = 3'd2;
	localparam logic [2:0] REG_SPR_ADR = 3'd3;
	localparam logic [2:0] REG_SPR_DAT = 3'd4;
	localparam logic [2:0] REG_SCROLL  = 3'd5;
	localparam logic [2:0] REG_ADDR    = 3'd6;
	localparam logic [2:0] REG_DATA    = 3'd7;

	localparam int SPRITE_BYTES = 256;
	localparam int SPR_AW = $clog2(SPRITE_BYTES);

	localparam logic [8:0] DOT_LAST  = 9'd340;
	localparam logic [8:0] LINE_LAST = 9'd261;
	localparam logic [8:0] LINE_RST  = 9'd240;

	typedef struct packed {
		logic [8:0] dot;
		logic [8:0] line;
	} pos_t;

	// one dot of scroll counter work on the current address
	function automatic logic [15:0] scroll_step(input logic [15:0] v_in,
		input logic [15:0] t, input pos_t p);
		logic [15:0] v;
		logic pre;
		logic rl;
		logic fetch;
		logic [4:0] cx;
		logic [4:0] cy;
		logic [2:0] fy;
		v = v_in;
		pre = (p.line == LINE_LAST);
		rl = pre || (p.line < 9'd240);
		fetch = (p.dot >= 9'd1 && p.dot <= 9'd256) || (p.dot >= 9'd321 && p.dot <= 9'd336);
		if (pre && p.dot >= 9'd280 && p.dot <= 9'd304)
			v = (v & 16'h841F) | (t & 16'h7BE0);
		if (rl) begin
			if (fetch && p.dot[2:0] == 3'd0) begin
				cx = v[4:0];
				if (cx == 5'd31)
					v = v ^ 16'h0400;
				v = (v & 16'hFFE0) | {11'd0, cx + 5'd1};
			end
			if (p.dot == 9'd256) begin
				fy = v[14:12];
				if (fy == 3'd7) begin
					cy = v[9:5];
					if (cy == 5'd29) begin
						v = v ^ 16'h0800;
						cy = 5'd0;
					end else begin
						cy = cy + 5'd1;
					end
					v = (v & 16'hFC1F) | {6'd0, cy, 5'd0};
				end
				v = (v & 16'h8FFF) | {1'b0, fy + 3'd1, 12'd0};
			end else if (p.dot == 9'd257) begin
				v = (v & 16'hFBE0) | (t & 16'h041F);
			end
		end
		return v;
	endfunction

endpackage

// File: src/video_register_port_and_scroll_timing_core.sv
// top level: cpu register port, scroll address logic and dot timing
//  channel | signals                                            | role
//  in      | in_valid in_ready func reg_index write_data ...    | tick, read or write
//  out     | out_valid out_ready read_data mem_address ...      | one result per item
// one item per cycle unless the output stalls; state and result latch on acceptance
// the result register frees when taken, so in_ready = !out_valid || out_ready
// sprite store: 256 bytes with one valid bit per byte, cleared at reset
// sprite data at the next address is read into a register as each item is accepted
// reset puts the timing counter at dot 340, line 240 and the port registers at zero
module video_register_port_and_scroll_timing_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [2:0]  reg_index,
	input  logic [7:0]  write_data,
	input  logic [7:0]  mem_byte,
	input  logic [7:0]  mem_byte_below,
	input  logic        zero_hit_event,
	input  logic        overflow_event,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  read_data,
	output logic [15:0] mem_address,
	output logic        mem_write,
	output logic [15:0] next_address,
	output logic        nmi_pulse,
	output logic [8:0]  dot,
	output logic [8:0]  line,
	output logic [2:0]  fine_x
);
	logic [7:0] control_q, mask_q, last_q, spr_addr_q, rbuf_q;
	logic [2:0] status_q, fine_q;
	logic [15:0] t_q, v_q;
	logic toggle_q;
	logic [7:0] spr_mem [vrps_pkg::SPRITE_BYTES];
	logic [vrps_pkg::SPRITE_BYTES-1:0] spr_vld_q;
	logic [7:0] spr_rdata_q;
	logic spr_hit_q;

	logic acc, tick;
	vrps_pkg::pos_t pos, pos_n;

	logic [7:0] control_d, mask_d, last_d, spr_addr_d, rbuf_d, rd_d;
	logic [2:0] status_d, fine_d;
	logic [15:0] t_d, v_d, step;
	logic toggle_d, wr_d, nmi_d, spr_we;

	assign in_ready = !out_valid || out_ready;
	assign acc = in_valid && in_ready;
	assign tick = acc && func == vrps_pkg::FUNC_TICK;

	vrps_timing u_timing (
		.clk(clk), .arst_n(arst_n), .adv(tick), .pos_next(pos_n), .pos(pos)
	);

	always_comb begin
		control_d = control_q; mask_d = mask_q; last_d = last_q;
		spr_addr_d = spr_addr_q; rbuf_d = rbuf_q; status_d = status_q;
		fine_d = fine_q; t_d = t_q; v_d = v_q; toggle_d = toggle_q;
		rd_d = 8'd0; wr_d = 1'b0; nmi_d = 1'b0; spr_we = 1'b0;
		step = control_q[2] ? 16'd32 : 16'd1;
		case (func)
			vrps_pkg::FUNC_TICK: begin
				if (mask_q[4] || mask_q[3])
					v_d = vrps_pkg::scroll_step(v_q, t_q, pos_n);
				if (zero_hit_event) status_d[1] = 1'b1;
				if (overflow_event) status_d[0] = 1'b1;
				if (pos_n.line == 9'd241 && pos_n.dot == 9'd1) begin
					status_d[2] = 1'b1;
					nmi_d = control_q[7];
				end
				if (pos_n.line == 9'd260 && pos_n.dot == 9'd329)
					status_d = 3'd0;
			end
			vrps_pkg::FUNC_READ: begin
				unique case (reg_index)
					vrps_pkg::REG_STATUS: begin
						rd_d = {status_q, last_q[4:0]};
						status_d[2] = 1'b0;
						toggle_d = 1'b0;
					end
					vrps_pkg::REG_SPR_DAT:
						rd_d = spr_hit_q ? spr_rdata_q : 8'd0;
					vrps_pkg::REG_DATA: begin
						if (v_q[13:0] < 14'h3F00) begin
							rd_d = rbuf_q;
							rbuf_d = mem_byte;
						end else begin
							rd_d = mem_byte;
							rbuf_d = mem_byte_below;
						end
						v_d = v_q + step;
					end
					default: rd_d = last_q;
				endcase
			end
			vrps_pkg::FUNC_WRITE: begin
				last_d = write_data;
				unique case (reg_index)
					vrps_pkg::REG_CTRL: begin
						control_d = write_data;
						t_d[11:10] = write_data[1:0];
					end
					vrps_pkg::REG_MASK: mask_d = write_data;
					vrps_pkg::REG_SPR_ADR: spr_addr_d = write_data;
					vrps_pkg::REG_SPR_DAT: begin
						spr_we = 1'b1;
						spr_addr_d = spr_addr_q + 8'd1;
					end
					vrps_pkg::REG_SCROLL: begin
						if (!toggle_q) begin
							t_d[4:0] = write_data[7:3];
							fine_d = write_data[2:0];
							toggle_d = 1'b1;
						end else begin
							t_d[14:12] = write_data[2:0];
							t_d[9:5] = write_data[7:3];
							toggle_d = 1'b0;
						end
					end
					vrps_pkg::REG_ADDR: begin
						if (!toggle_q) begin
							t_d[14:8] = {1'b0, write_data[5:0]};
							toggle_d = 1'b1;
						end else begin
							t_d[7:0] = write_data;
							v_d = {t_q[15:8], write_data};
							toggle_d = 1'b0;
						end
					end
					vrps_pkg::REG_DATA: begin
						v_d = v_q + step;
						wr_d = 1'b1;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// a write goes to the current pointer and the pointer then moves, so the
	// prefetch address never equals the address written in the same cycle
	always_ff @(posedge clk) begin
		if (acc && spr_we)
			spr_mem[spr_addr_q] <= write_data;
		if (acc)
			spr_rdata_q <= spr_mem[spr_addr_d];
		if (acc) begin
			read_data <= rd_d;
			mem_address <= v_q;
			mem_write <= wr_d;
			next_address <= v_d;
			nmi_pulse <= nmi_d;
			dot <= tick ? pos_n.dot : pos.dot;
			line <= tick ? pos_n.line : pos.line;
			fine_x <= fine_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_q <= '0; mask_q <= '0; last_q <= '0; spr_addr_q <= '0;
			rbuf_q <= '0; status_q <= '0; fine_q <= '0; t_q <= '0; v_q <= '0;
			toggle_q <= 1'b0; spr_vld_q <= '0; spr_hit_q <= 1'b0; out_valid <= 1'b0;
		end else begin
			if (acc) begin
				control_q <= control_d; mask_q <= mask_d; last_q <= last_d;
				spr_addr_q <= spr_addr_d; rbuf_q <= rbuf_d; status_q <= status_d;
				fine_q <= fine_d; t_q <= t_d; v_q <= v_d; toggle_q <= toggle_d;
				spr_hit_q <= spr_vld_q[spr_addr_d];
				if (spr_we)
					spr_vld_q[spr_addr_q] <= 1'b1;
			end
			if (acc)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
		end
	end

	a_nmi_only_tick: assert property (@(posedge clk) disable iff (!arst_n)
		acc && func != vrps_pkg::FUNC_TICK |=> !nmi_pulse) else $error("nmi on non-tick");
	a_write_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mem_write |-> next_address != mem_address) else $error("no step");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(next_address))
		else $error("result lost");
endmodule

// File: src/vrps_timing.sv
// dot and line counters with frame parity
module vrps_timing (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	output vrps_pkg::pos_t  pos_next,
	output vrps_pkg::pos_t  pos
);
	logic odd_frame_q;

	always_comb begin
		pos_next = pos;
		if (pos.dot == vrps_pkg::DOT_LAST) begin
			pos_next.dot = 9'd0;
			if (pos.line == vrps_pkg::LINE_LAST)
				pos_next.line = 9'd0;
			else
				pos_next.line = pos.line + 9'd1;
		end else begin
			pos_next.dot = pos.dot + 9'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos.dot <= vrps_pkg::DOT_LAST;
			pos.line <= vrps_pkg::LINE_RST;
			odd_frame_q <= 1'b0;
		end else if (adv) begin
			pos <= pos_next;
			if (pos.dot == vrps_pkg::DOT_LAST && pos.line == vrps_pkg::LINE_LAST)
				odd_frame_q <= ~odd_frame_q;
		end
	end
endmodule

// File: dv/vrps_checker.sv
// checker for the video register port core: predicts each result and compares it
module vrps_checker
	import vrps_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  func,
	input  logic [2:0]  reg_index,
	input  logic [7:0]  write_data,
	input  logic [7:0]  mem_byte,
	input  logic [7:0]  mem_byte_below,
	input  logic        zero_hit_event,
	input  logic        overflow_event,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  read_data,
	input  logic [15:0] mem_address,
	input  logic        mem_write,
	input  logic [15:0] next_address,
	input  logic        nmi_pulse,
	input  logic [8:0]  dot,
	input  logic [8:0]  line,
	input  logic [2:0]  fine_x,
	output int          fail_count,
	output int          pending,
	output int          nmi_seen,
	output int          vblank_reads
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0]  rd;
		logic [15:0] ma;
		logic        mw;
		logic [15:0] na;
		logic        nmi;
		logic [8:0]  dt;
		logic [8:0]  ln;
		logic [2:0]  fx;
	} video_result_t;

	video_result_t expected_results[$];

	logic [7:0]  ctrl_q, mask_q, last_wr_q, spr_ptr_q, rbuf_q;
	logic [2:0]  flags_q, fine_q;
	logic [7:0]  spr_mem[SPRITE_BYTES];
	logic [15:0] t_q, v_q;
	logic        latch_q;
	logic [8:0]  dot_q, line_q;

	function automatic logic [15:0] loopy_dot(input logic [15:0] vin);
		logic [15:0] v;
		logic pre, rl, fetch;
		logic [4:0] cx, cy;
		logic [2:0] fy;
		v = vin;
		pre = (line_q == 9'd261);
		rl = pre || (line_q < 9'd240);
		fetch = (dot_q >= 1 && dot_q <= 256) || (dot_q >= 321 && dot_q <= 336);
		if (pre && dot_q >= 280 && dot_q <= 304)
			v = (v & 16'h841F) | (t_q & 16'h7BE0);
		if (rl) begin
			if (fetch && dot_q[2:0] == 0) begin
				cx = v[4:0];
				if (cx == 31)
					v ^= 16'h0400;
				v[4:0] = cx + 5'd1;
			end
			if (dot_q == 256) begin
				fy = v[14:12];
				if (fy == 7) begin
					cy = v[9:5];
					if (cy == 29) begin
						v ^= 16'h0800;
						cy = 0;
					end else
						cy = cy + 5'd1;
					v[9:5] = cy;
				end
				v[14:12] = fy + 3'd1;
			end else if (dot_q == 257)
				v = (v & 16'hFBE0) | (t_q & 16'h041F);
		end
		return v;
	endfunction

	task automatic predict_video_step(output video_result_t r);
		logic [15:0] stepv;
		r = '0;
		r.ma = v_q;
		stepv = ctrl_q[2] ? 16'd32 : 16'd1;
		if (func == FUNC_TICK) begin
			if (dot_q == DOT_LAST) begin
				dot_q = 0;
				line_q = (line_q == LINE_LAST) ? 9'd0 : line_q + 9'd1;
			end else
				dot_q = dot_q + 9'd1;
			if (mask_q & 8'h18)
				v_q = loopy_dot(v_q);
			if (zero_hit_event) flags_q[1] = 1;
			if (overflow_event) flags_q[0] = 1;
			if (line_q == 241 && dot_q == 1) begin
				flags_q[2] = 1;
				r.nmi = ctrl_q[7];
			end
			if (line_q == 260 && dot_q == 329)
				flags_q = 0;
		end else if (func == FUNC_READ) begin
			case (reg_index)
				REG_STATUS: begin
					r.rd = {flags_q, last_wr_q[4:0]};
					if (flags_q[2]) vblank_reads++;
					flags_q[2] = 0;
					latch_q = 0;
				end
				REG_SPR_DAT: r.rd = spr_mem[spr_ptr_q];
				REG_DATA: begin
					if (v_q[13:0] < 14'h3F00) begin
						r.rd = rbuf_q;
						rbuf_q = mem_byte;
					end else begin
						r.rd = mem_byte;
						rbuf_q = mem_byte_below;
					end
					v_q = v_q + stepv;
				end
				default: r.rd = last_wr_q;
			endcase
		end else if (func == FUNC_WRITE) begin
			last_wr_q = write_data;
			case (reg_index)
				REG_CTRL: begin
					ctrl_q = write_data;
					t_q[11:10] = write_data[1:0];
				end
				REG_MASK: mask_q = write_data;
				REG_SPR_ADR: spr_ptr_q = write_data;
				REG_SPR_DAT: begin
					spr_mem[spr_ptr_q] = write_data;
					spr_ptr_q = spr_ptr_q + 8'd1;
				end
				REG_SCROLL: begin
					if (!latch_q) begin
						t_q[4:0] = write_data[7:3];
						fine_q = write_data[2:0];
					end else begin
						t_q[14:12] = write_data[2:0];
						t_q[9:5] = write_data[7:3];
					end
					latch_q = !latch_q;
				end
				REG_ADDR: begin
					if (!latch_q)
						t_q[14:8] = {1'b0, write_data[5:0]};
					else begin
						t_q[7:0] = write_data;
						v_q = t_q;
					end
					latch_q = !latch_q;
				end
				REG_DATA: begin
					v_q = v_q + stepv;
					r.mw = 1;
				end
				default: ;
			endcase
		end
		r.na = v_q;
		r.dt = dot_q;
		r.ln = line_q;
		r.fx = fine_q;
	endtask

	always @(posedge clk or negedge arst_n) begin
		video_result_t e, got;
		if (!arst_n) begin
			ctrl_q = 0; mask_q = 0; flags_q = 0; last_wr_q = 0; spr_ptr_q = 0;
			foreach (spr_mem[i]) spr_mem[i] = 0;
			t_q = 0; v_q = 0; fine_q = 0; latch_q = 0; rbuf_q = 0;
			dot_q = DOT_LAST; line_q = LINE_RST;
			expected_results.delete();
			fail_count = 0; pending = 0; nmi_seen = 0; vblank_reads = 0;
		end else begin
			if (out_valid && out_ready) begin
				got = {read_data, mem_address, mem_write, next_address, nmi_pulse,
					dot, line, fine_x};
				if (expected_results.size() == 0) begin
					$display("%0t: result with nothing expected, actual %h", $time, got);
					fail_count++;
				end else begin
					e = expected_results.pop_front();
					if (e !== got) begin
						fail_count++;
						$display("%0t: mismatch expected rd=%h ma=%h mw=%b na=%h nmi=%b dot=%0d line=%0d fx=%0d",
							$time, e.rd, e.ma, e.mw, e.na, e.nmi, e.dt, e.ln, e.fx);
						$display("%0t:          actual rd=%h ma=%h mw=%b na=%h nmi=%b dot=%0d line=%0d fx=%0d",
							$time, got.rd, got.ma, got.mw, got.na, got.nmi, got.dt, got.ln, got.fx);
					end
					if (got.nmi) nmi_seen++;
				end
			end
			if (in_valid && in_ready) begin
				predict_video_step(e);
				expected_results.push_back(e);
			end
			pending = expected_results.size();
		end
	end
endmodule

// File: dv/tb_top.sv
// testbench top for the video register port core: stimulus, watchdog and verdict
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_ready, out_valid, out_ready = 0;
	logic [1:0] func = 0;
	logic [2:0] reg_index = 0;
	logic [7:0] write_data = 0, mem_byte = 0, mem_byte_below = 0;
	logic zero_hit_event = 0, overflow_event = 0;
	logic [7:0] read_data;
	logic [15:0] mem_address, next_address;
	logic mem_write, nmi_pulse;
	logic [8:0] dot, line;
	logic [2:0] fine_x;
	int fail_count, pending, nmi_seen, vblank_reads, items_sent, idle_cycles;

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	video_register_port_and_scroll_timing_core uut (.*);

	vrps_checker chk (.*);

	// receiver stall pattern
	always @(posedge clk) begin
		int phase;
		phase = (phase + 1) % 64;
		out_ready <= (phase < 20) ? 1'b1 : ($urandom_range(3) != 0);
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else if (++idle_cycles > 2000) begin
			$display("watchdog expired");
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic send(input logic [1:0] f, input logic [2:0] r, input logic [7:0] d,
		input logic zh = 0, input logic ov = 0);
		func <= f;
		reg_index <= r;
		write_data <= d;
		mem_byte <= 8'($urandom);
		mem_byte_below <= 8'($urandom);
		zero_hit_event <= zh;
		overflow_event <= ov;
		in_valid <= 1;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic gap();
		in_valid <= 0;
		repeat ($urandom_range(4)) @(posedge clk);
	endtask

	task automatic random_item();
		int k;
		logic [2:0] r;
		k = $urandom_range(99);
		r = 3'($urandom);
		if (k < 45)
			send(vrps_pkg::FUNC_TICK, r, 8'($urandom), $urandom_range(15) == 0,
				$urandom_range(15) == 0);
		else if (k < 70)
			send(vrps_pkg::FUNC_READ, r, 8'($urandom));
		else if (k < 97)
			send(vrps_pkg::FUNC_WRITE, r,
				(r == vrps_pkg::REG_MASK) ? (8'($urandom) | 8'h08) : 8'($urandom));
		else
			send(vrps_pkg::FUNC_NONE, r, 8'($urandom), 1'($urandom), 1'($urandom));
	endtask

	initial begin
		int burst;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: every register both ways, extremes, palette read, status write
		send(vrps_pkg::FUNC_WRITE, vrps_pkg::REG_CTRL, 8'hFF);
		send(vrps_pkg::FUNC_WRITE, vrps_pkg::REG_MASK, 8'h18);
		send(vrps_pkg::FUNC_WRITE, vrps_pkg::REG_STATUS, 8'hAA);
		send(vrps_pkg::FUNC_WRITE, vrps_pkg::REG_SPR_ADR, 8'hFF);
		send(vrps_pkg::FUNC_WRITE, vrps_pkg::REG_SPR_DAT, 8'h5A);
		send(vrps_pkg::FUNC_WRITE, vrps_pkg::REG_SPR_DAT, 8'h00);
		send(vrps_pkg::FUNC_WRITE, vrps_pkg::REG_SPR_ADR, 8'hFF);
		send(vrps_pkg::FUNC_READ, vrps_pkg::REG_SPR_DAT, 8'h00);
		send(vrps_pkg::FUNC_WRITE, vrps_pkg::REG_SCROLL, 8'hFF);
		send(vrps_pkg::FUNC_WRITE, vrps_pkg::REG_SCROLL, 8'hEF);
		send(vrps_pkg::FUNC_WRITE, vrps_pkg::REG_ADDR, 8'hFF);
		send(vrps_pkg::FUNC_WRITE, vrps_pkg::REG_ADDR, 8'h00);
		send(vrps_pkg::FUNC_READ, vrps_pkg::REG_DATA, 8'h00);
		send(vrps_pkg::FUNC_WRITE, vrps_pkg::REG_DATA, 8'h11);
		send(vrps_pkg::FUNC_READ, vrps_pkg::REG_STATUS, 8'h00);
		for (int r = 0; r < 8; r++)
			if (r[2:0] != vrps_pkg::REG_STATUS && r[2:0] != vrps_pkg::REG_SPR_DAT &&
				r[2:0] != vrps_pkg::REG_DATA)
				send(vrps_pkg::FUNC_READ, r[2:0], 8'h00);
		send(vrps_pkg::FUNC_NONE, vrps_pkg::REG_DATA, 8'hFF, 1, 1);
		send(vrps_pkg::FUNC_TICK, 3'd0, 8'h00, 1, 1);
		send(vrps_pkg::FUNC_WRITE, vrps_pkg::REG_CTRL, 8'h80);
		// next tick lands on the vblank dot with nmi enabled
		send(vrps_pkg::FUNC_TICK, 3'd0, 8'h00);
		send(vrps_pkg::FUNC_READ, vrps_pkg::REG_STATUS, 8'h00);
		// random: tick runs with scroll logic active between register accesses
		while (items_sent < 900) begin
			burst = $urandom_range(1, 30);
			repeat (burst) random_item();
			if ($urandom_range(2) == 0) gap();
		end
		in_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (5) @(posedge clk);
		$display("sent %0d items across register access, palette reads and ticks",
			items_sent);
		$display("nmi pulses seen %0d, status reads with vblank %0d", nmi_seen, vblank_reads);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
